// ----- src/sqb_pkg.sv -----
// Shared types and codes for the stack/queue buffer.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package sqb_pkg;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_DEQUEUE = 3'd1;
    localparam logic [2:0] MODE_PUSH = 3'd2;
    localparam logic [2:0] MODE_POP = 3'd3;
    localparam logic [2:0] MODE_DUMP = 3'd4;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

    localparam int WORD_W = 32;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } t_state;

    typedef struct packed {
        logic       wr_tail;
        logic       wr_head;
        logic       rd_head;
        logic       dump_start;
        logic       dump_next;
        logic       load_direct;
        logic       load_ram;
        logic [1:0] direct_status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic left_zero;
    } t_dp_stat;

endpackage

// ----- src/stack_queue_buffer.sv -----
// Double-ended queue of signed 32-bit words; top level over sqb_ctrl and sqb_dp.
// Insert, full, empty and invalid results load the output register directly;
// removed and dumped entries pass the RAM read register, then the output register.
// Inserts take 1 item per cycle unless stalled; a remove or dump stalls till done.
// Reset clears head, count and output valid; the entry RAM is not cleared.
`timescale 1ns / 1ps

module stack_queue_buffer
    import sqb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value_res,
    output logic [1:0]         o_status,
    output logic               o_last
);

    t_cmd     cmd;
    t_dp_stat stat;

    sqb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_mode (i_mode),
        .i_stat (stat),
        .o_stall(o_stall),
        .o_cmd  (cmd)
    );

    sqb_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_value),
        .i_stall    (i_stall),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_value_res(o_value_res),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

// ----- src/sqb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sqb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/sqb_ctrl.sv -----
// Controller state machine: decodes the mode of each beat and sequences
// removes and dumps. Depends on sqb_pkg.
`timescale 1ns / 1ps

module sqb_ctrl
    import sqb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic [2:0] i_mode,
    input  t_dp_stat i_stat,
    output logic     o_stall,
    output t_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_remove;

    assign accept = (r_state == ST_IDLE) && i_valid && i_stat.out_free;
    assign is_remove = (i_mode == MODE_DEQUEUE) || (i_mode == MODE_POP);
    assign o_stall = !((r_state == ST_IDLE) && i_stat.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && !i_stat.empty && (is_remove || (i_mode == MODE_DUMP))) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (i_stat.out_free && i_stat.left_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.direct_status = STAT_OK;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_APPEND, MODE_PUSH: begin
                            o_cmd.load_direct = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.direct_status = STAT_FULL;
                            end else if (i_mode == MODE_APPEND) begin
                                o_cmd.wr_tail = 1'b1;
                            end else begin
                                o_cmd.wr_head = 1'b1;
                            end
                        end
                        MODE_DEQUEUE, MODE_POP: begin
                            if (i_stat.empty) begin
                                o_cmd.load_direct = 1'b1;
                                o_cmd.direct_status = STAT_EMPTY;
                            end else begin
                                o_cmd.rd_head = 1'b1;
                            end
                        end
                        MODE_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.load_direct = 1'b1;
                                o_cmd.direct_status = STAT_EMPTY;
                            end else begin
                                o_cmd.dump_start = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.load_direct = 1'b1;
                            o_cmd.direct_status = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_ram = 1'b1;
                    o_cmd.dump_next = !i_stat.left_zero;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- src/sqb_dp.sv -----
// Datapath: head pointer, entry count, dump walker, entry RAM and the
// output register. Depends on sqb_pkg and sqb_ram.
`timescale 1ns / 1ps

module sqb_dp
    import sqb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_stall,
    output t_dp_stat                 o_stat,
    output logic                     o_valid,
    output logic signed [WORD_W-1:0] o_value_res,
    output logic [1:0]               o_status,
    output logic                     o_last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [PW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_walk;
    logic [CW-1:0] r_left;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_value;
    logic [1:0]               r_status;
    logic                     r_last;

    logic [PW-1:0]     head_inc;
    logic [PW-1:0]     head_dec;
    logic [PW-1:0]     walk_inc;
    logic [PW:0]       tail_sum;
    logic [PW-1:0]     tail_idx;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + PW'(1);
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - PW'(1);
    assign walk_inc = (r_walk == LAST_IDX) ? '0 : r_walk + PW'(1);
    assign tail_sum = {1'b0, r_head} + (PW + 1)'(r_count);
    assign tail_idx = (tail_sum >= DEPTH_W) ? PW'(tail_sum - DEPTH_W) : tail_sum[PW-1:0];

    assign wr_en = i_cmd.wr_tail || i_cmd.wr_head;
    assign wr_addr = i_cmd.wr_head ? head_dec : tail_idx;
    assign rd_en = i_cmd.rd_head || i_cmd.dump_start || i_cmd.dump_next;
    assign rd_addr = i_cmd.dump_next ? r_walk : r_head;

    sqb_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_value),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
            r_walk <= '0;
            r_left <= '0;
        end else begin
            if (i_cmd.wr_tail) begin
                r_count <= r_count + ONE_C;
            end
            if (i_cmd.wr_head) begin
                r_head <= head_dec;
                r_count <= r_count + ONE_C;
            end
            if (i_cmd.rd_head) begin
                r_head <= head_inc;
                r_count <= r_count - ONE_C;
                r_left <= '0;
            end
            if (i_cmd.dump_start) begin
                r_walk <= head_inc;
                r_left <= r_count - ONE_C;
            end
            if (i_cmd.dump_next) begin
                r_walk <= walk_inc;
                r_left <= r_left - ONE_C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_direct || i_cmd.load_ram) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            r_value <= '0;
            r_status <= i_cmd.direct_status;
            r_last <= 1'b1;
        end else if (i_cmd.load_ram) begin
            r_value <= rd_data;
            r_status <= STAT_OK;
            r_last <= (r_left == '0);
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full = (r_count == DEPTH_C);
    assign o_stat.out_free = !r_out_valid || !i_stall;
    assign o_stat.left_zero = (r_left == '0);

    assign o_valid = r_out_valid;
    assign o_value_res = r_value;
    assign o_status = r_status;
    assign o_last = r_last;

endmodule

// ----- src/sqb_checker.sv -----
// Port-level assertions for stack_queue_buffer, bound to the top level.
// Depends on sqb_pkg.
`timescale 1ns / 1ps

module sqb_checker
    import sqb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [2:0]         i_mode,
    input logic signed [31:0] i_value,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_value_res,
    input logic [1:0]         o_status,
    input logic               o_last
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value_res) && $stable(o_status)
            && $stable(o_last))
        else $error("stalled result changed");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_OK) |-> o_last && (o_value_res == 32'sd0))
        else $error("error result not single or not zero");

    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode > MODE_DUMP)
            |=> o_valid && (o_status == STAT_INVALID))
        else $error("invalid mode not flagged");

    a_insert_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && ((i_mode == MODE_APPEND) || (i_mode == MODE_PUSH))
            |=> o_valid && o_last && ((o_status == STAT_OK) || (o_status == STAT_FULL)))
        else $error("insert result wrong");

endmodule

bind stack_queue_buffer sqb_checker u_sqb_checker (.*);
